// ===== hw/rtl/iba_pkg.sv =====
//------------------------------------------------------------------------------
// iba_pkg
// Shared constants and codes of the indexed block allocator.
//------------------------------------------------------------------------------
package iba_pkg;

    localparam int NUM_BLOCKS_DEF      = 64;
    localparam int BYTES_PER_BLOCK_DEF = 16;
    localparam int FILE_SLOTS_DEF      = 16;
    localparam int INDEX_ENTRIES       = 16;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_RESIZE = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_MAP    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_SPACE  = 3'd4;
    localparam logic [2:0] ST_BAD_POS   = 3'd5;

endpackage

// ===== hw/rtl/indexed_block_allocator.sv =====
//------------------------------------------------------------------------------
// indexed_block_allocator
// Indexed disk-block allocator with a LIFO free stack and per-slot index blocks.
//
// The s_axis channel takes one request word: action, file slot, byte length
// and block position. The m_axis channel returns one result word per request:
// status, block number, free count, file blocks and file bytes. A small
// sequencer moves blocks between the free stack memory and the index entry
// memory one per step, using a single shared read port on each memory. A
// refused request goes from decode straight to the result; a create pops its
// index block, a map reads one entry, and a resize or delete moves its blocks
// one by one first. The next request is taken in the cycle after the result
// word is accepted, and the block is not ready meanwhile. Reset and a
// total_blocks write refill the free stack with a clearing pass over all
// NUM_BLOCKS entries (one entry per cycle) during which no request is taken;
// slots are invalidated at once. When the receiver stalls, the result is held
// in the output register and the next request waits.
//------------------------------------------------------------------------------
module indexed_block_allocator
    import iba_pkg::*;
#(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int BYTES_PER_BLOCK = BYTES_PER_BLOCK_DEF,
    parameter int FILE_SLOTS      = FILE_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], file_slot[5:2], byte_length[14:6], block_position[18:15]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], block_number[8:3], free_count[15:9], file_blocks[20:16],
    // file_bytes[29:21]
    output logic [31:0] m_axis_tdata
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int TW = $clog2(NUM_BLOCKS + 1);
    localparam int SW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int EW = $clog2(INDEX_ENTRIES);
    localparam int CW = EW + 1;
    localparam int AW = BW + EW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_POPRD = 4'd3;
    localparam logic [3:0] S_POPWR = 4'd4;
    localparam logic [3:0] S_PSHRD = 4'd5;
    localparam logic [3:0] S_PSHWR = 4'd6;
    localparam logic [3:0] S_IDXPS = 4'd7;
    localparam logic [3:0] S_MAPRD = 4'd8;
    localparam logic [3:0] S_MAPWT = 4'd9;
    localparam logic [3:0] S_CRRD  = 4'd10;
    localparam logic [3:0] S_CRWT  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [BW-1:0] stack_mem [NUM_BLOCKS];
    logic [BW-1:0] entry_mem [NUM_BLOCKS*INDEX_ENTRIES];
    logic [BW-1:0] stack_rd_reg, entry_rd_reg;

    logic [FILE_SLOTS-1:0] valid_reg, valid_next;
    logic [BW-1:0] sidx_mem [FILE_SLOTS];
    logic [CW-1:0] sdat_mem [FILE_SLOTS];
    logic [8:0]    ssiz_mem [FILE_SLOTS];
    logic [BW-1:0] sidx_rd_reg;
    logic [CW-1:0] sdat_rd_reg;
    logic [8:0]    ssiz_rd_reg;

    logic [3:0]    state_reg, state_next;
    logic [TW-1:0] top_reg, top_next, total_reg, total_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [1:0]    act_reg, act_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          inr_reg, inr_next;
    logic [8:0]    len_reg, len_next;
    logic [3:0]    pos_reg, pos_next;
    logic [CW-1:0] cur_reg, cur_next, need_reg, need_next;
    logic [BW-1:0] ib_reg, ib_next;
    logic [2:0]    st_reg, st_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic          out_v_reg, out_v_next;
    logic [31:0]   out_reg, out_next;

    logic          stk_we, ent_we, slot_we;
    logic [BW-1:0] stk_wa, stk_wd, stk_ra, ent_wd, slot_ib_wd;
    logic [AW-1:0] ent_wa, ent_ra;
    logic [CW-1:0] slot_dat_wd;
    logic [8:0]    slot_siz_wd;
    logic [9:0]    len_ceil;
    logic [TW-1:0] cfg_clip;

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stack_rd_reg <= stack_mem[stk_ra];
        if (ent_we)
        begin
            entry_mem[ent_wa] <= ent_wd;
        end
        entry_rd_reg <= entry_mem[ent_ra];
        if (slot_we)
        begin
            sidx_mem[slot_reg] <= slot_ib_wd;
            sdat_mem[slot_reg] <= slot_dat_wd;
            ssiz_mem[slot_reg] <= slot_siz_wd;
        end
        sidx_rd_reg <= sidx_mem[slot_next];
        sdat_rd_reg <= sdat_mem[slot_next];
        ssiz_rd_reg <= ssiz_mem[slot_next];
    end

    always_comb
    begin
        if (cfg_wdata == 7'd0)
        begin
            cfg_clip = TW'(1);
        end
        else if ({25'd0, cfg_wdata} > NUM_BLOCKS)
        begin
            cfg_clip = TW'(NUM_BLOCKS);
        end
        else
        begin
            cfg_clip = TW'(cfg_wdata);
        end
    end

    assign len_ceil = {1'b0, len_reg} + 10'(BYTES_PER_BLOCK - 1);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        total_next  = total_reg;
        clr_next    = clr_reg;
        act_next    = act_reg;
        slot_next   = slot_reg;
        inr_next    = inr_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        need_next   = need_reg;
        ib_next     = ib_reg;
        st_next     = st_reg;
        blk_next    = blk_reg;
        valid_next  = valid_reg;
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        stk_we      = 1'b0;
        stk_wa      = BW'(clr_reg);
        stk_wd      = BW'(clr_reg);
        stk_ra      = BW'(top_reg - TW'(1));
        ent_we      = 1'b0;
        ent_wa      = {ib_reg, cur_reg[EW-1:0]};
        ent_wd      = stack_rd_reg;
        ent_ra      = {ib_reg, EW'(cur_reg - CW'(1))};
        slot_we     = 1'b0;
        slot_ib_wd  = ib_reg;
        slot_dat_wd = cur_reg;
        slot_siz_wd = len_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                stk_we   = 1'b1;
                clr_next = clr_reg + TW'(1);
                if (clr_reg == TW'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tdata[1:0];
                    inr_next   = {28'd0, s_axis_tdata[5:2]} < FILE_SLOTS;
                    slot_next  = SW'(s_axis_tdata[5:2]);
                    len_next   = s_axis_tdata[14:6];
                    pos_next   = s_axis_tdata[18:15];
                    st_next    = ST_OK;
                    blk_next   = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                ib_next    = sidx_rd_reg;
                cur_next   = sdat_rd_reg;
                len_next   = ssiz_rd_reg;
                need_next  = CW'(len_ceil / BYTES_PER_BLOCK);
                state_next = S_DONE;
                if (!inr_reg)
                begin
                    st_next = ST_NOT_FOUND;
                end
                else if (act_reg == ACT_CREATE)
                begin
                    if (valid_reg[slot_reg])
                    begin
                        st_next = ST_EXISTS;
                    end
                    else if (top_reg == '0)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_CRRD;
                    end
                end
                else if (!valid_reg[slot_reg])
                begin
                    st_next = ST_NOT_FOUND;
                end
                else if (act_reg == ACT_RESIZE)
                begin
                    if ((len_ceil / BYTES_PER_BLOCK) > INDEX_ENTRIES ||
                        ((len_ceil / BYTES_PER_BLOCK) > 10'(sdat_rd_reg) &&
                         (len_ceil / BYTES_PER_BLOCK) - 10'(sdat_rd_reg)
                         > 10'(top_reg)))
                    begin
                        st_next = ST_NO_SPACE;
                    end
                    else
                    begin
                        len_next   = len_reg;
                        state_next = S_POPRD;
                    end
                end
                else if (act_reg == ACT_DELETE)
                begin
                    need_next  = '0;
                    state_next = S_PSHRD;
                end
                else
                begin
                    if (10'(pos_reg) >= 10'(sdat_rd_reg))
                    begin
                        st_next = ST_BAD_POS;
                    end
                    else
                    begin
                        state_next = S_MAPRD;
                    end
                end
            end
            S_CRRD:
            begin
                top_next   = top_reg - TW'(1);
                state_next = S_CRWT;
            end
            S_CRWT:
            begin
                blk_next   = stack_rd_reg;
                ib_next    = stack_rd_reg;
                cur_next   = '0;
                len_next   = '0;
                valid_next[slot_reg] = 1'b1;
                state_next = S_DONE;
            end
            S_POPRD:
            begin
                if (need_reg > cur_reg)
                begin
                    top_next   = top_reg - TW'(1);
                    state_next = S_POPWR;
                end
                else
                begin
                    state_next = S_PSHRD;
                end
            end
            S_POPWR:
            begin
                ent_we     = 1'b1;
                cur_next   = cur_reg + CW'(1);
                state_next = S_POPRD;
            end
            S_PSHRD:
            begin
                if (cur_reg > need_reg)
                begin
                    state_next = S_PSHWR;
                end
                else if (act_reg == ACT_DELETE)
                begin
                    state_next = S_IDXPS;
                end
                else
                begin
                    slot_we    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_PSHWR:
            begin
                stk_we     = top_reg < TW'(NUM_BLOCKS);
                stk_wa     = BW'(top_reg);
                stk_wd     = entry_rd_reg;
                if (top_reg < TW'(NUM_BLOCKS))
                begin
                    top_next = top_reg + TW'(1);
                end
                cur_next   = cur_reg - CW'(1);
                state_next = S_PSHRD;
            end
            S_IDXPS:
            begin
                stk_we     = top_reg < TW'(NUM_BLOCKS);
                stk_wa     = BW'(top_reg);
                stk_wd     = ib_reg;
                if (top_reg < TW'(NUM_BLOCKS))
                begin
                    top_next = top_reg + TW'(1);
                end
                valid_next[slot_reg] = 1'b0;
                state_next = S_DONE;
            end
            S_MAPRD:
            begin
                ent_ra     = {ib_reg, pos_reg[EW-1:0]};
                state_next = S_MAPWT;
            end
            S_MAPWT:
            begin
                blk_next   = entry_rd_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (act_reg == ACT_CREATE && st_reg == ST_OK)
                begin
                    slot_we = 1'b1;
                end
                out_next   = '0;
                out_next[2:0]  = st_reg;
                out_next[8:3]  = 6'(blk_reg);
                out_next[15:9] = 7'(top_reg);
                if (inr_reg && valid_next[slot_reg])
                begin
                    out_next[20:16] = 5'(cur_reg + CW'(1));
                    out_next[29:21] = len_reg;
                end
                out_v_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_v_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            total_next = cfg_clip;
            top_next   = cfg_clip;
            valid_next = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            top_reg   <= TW'(NUM_BLOCKS);
            total_reg <= TW'(NUM_BLOCKS);
            clr_reg   <= '0;
            valid_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        slot_reg <= slot_next;
        inr_reg  <= inr_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        need_reg <= need_next;
        ib_reg   <= ib_next;
        st_reg   <= st_next;
        blk_reg  <= blk_next;
        out_reg  <= out_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && (total_reg != '0);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed block allocator. Each request word
// accepted by the block updates a local model of the free stack, the file
// slots and the index entries. That model predicts the result word, and each
// word that arrives is compared with it field by field.
//------------------------------------------------------------------------------
module tb_top;
    import iba_pkg::*;

    localparam int NBLK      = 64;
    localparam int BPB       = 16;
    localparam int NSLOT     = 16;
    localparam int QUIET_MAX = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [3:0] block_position;
        logic [8:0] byte_length;
        logic [3:0] file_slot;
        logic [1:0] action;
    } req_t;

    typedef struct packed {
        logic [8:0] file_bytes;
        logic [4:0] file_blocks;
        logic [6:0] free_count;
        logic [5:0] block_number;
        logic [2:0] status;
    } rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    indexed_block_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [5:0] free_stack [NBLK];
    int         free_top;
    bit         slot_live [NSLOT];
    logic [5:0] slot_iblk [NSLOT];
    int         slot_nblk [NSLOT];
    int         slot_len  [NSLOT];
    logic [5:0] index_mem [NBLK*16];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   errors;
    int   quiet;
    int   sent;
    int   got;
    bit   hold_off;
    bit   stall_long;
    int   long_left;
    bit   in_acc;
    int   burst_left;
    int   gap_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void disk_refill(input int total);
        for (int i = 0; i < NBLK; i++)
            free_stack[i] = i[5:0];
        free_top = total;
        for (int i = 0; i < NSLOT; i++)
            slot_live[i] = 1'b0;
    endfunction

    function automatic logic [5:0] take_block();
        if (free_top == 0)
            return 6'd0;
        free_top--;
        return free_stack[free_top];
    endfunction

    function automatic void give_block(input logic [5:0] b);
        if (free_top < NBLK)
        begin
            free_stack[free_top] = b;
            free_top++;
        end
    endfunction

    function automatic int entry_at(input int s, input int p);
        return int'(slot_iblk[s]) * 16 + (p % 16);
    endfunction

    function automatic rsp_t allocate_step(input req_t r);
        rsp_t o;
        int   s;
        int   need;
        int   cur;
        s = r.file_slot;
        o = '0;
        o.status = ST_OK;
        if (r.action == ACT_CREATE)
        begin
            if (slot_live[s])
                o.status = ST_EXISTS;
            else if (free_top == 0)
                o.status = ST_FULL;
            else
            begin
                o.block_number = take_block();
                slot_iblk[s] = o.block_number;
                slot_nblk[s] = 0;
                slot_len[s] = 0;
                slot_live[s] = 1'b1;
            end
        end
        else if (!slot_live[s])
            o.status = ST_NOT_FOUND;
        else if (r.action == ACT_RESIZE)
        begin
            need = (int'(r.byte_length) + BPB - 1) / BPB;
            cur = slot_nblk[s];
            if (need > INDEX_ENTRIES || (need > cur && need - cur > free_top))
                o.status = ST_NO_SPACE;
            else
            begin
                if (need > cur)
                    for (int i = cur; i < need; i++)
                        index_mem[entry_at(s, i)] = take_block();
                else
                    for (int i = cur; i > need; i--)
                        give_block(index_mem[entry_at(s, i - 1)]);
                slot_nblk[s] = need;
                slot_len[s] = r.byte_length;
            end
        end
        else if (r.action == ACT_DELETE)
        begin
            for (int i = slot_nblk[s]; i > 0; i--)
                give_block(index_mem[entry_at(s, i - 1)]);
            give_block(slot_iblk[s]);
            slot_live[s] = 1'b0;
        end
        else
        begin
            if (r.block_position >= slot_nblk[s])
                o.status = ST_BAD_POS;
            else
                o.block_number = index_mem[entry_at(s, r.block_position)];
        end
        o.free_count = free_top[6:0];
        if (slot_live[s])
        begin
            o.file_blocks = 5'(slot_nblk[s] + 1);
            o.file_bytes = slot_len[s][8:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        $display("mismatch on result %0d: %s got %0d expected %0d", got, what, got_v, exp_v);
        errors++;
    endtask

    function automatic req_t make_req(input logic [1:0] a, input int s, input int len,
                                      input int p);
        req_t r;
        r.action = a;
        r.file_slot = s[3:0];
        r.byte_length = len[8:0];
        r.block_position = p[3:0];
        return r;
    endfunction

    function automatic void queue_req(input req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // Sender: bursts with gaps; while hold_off is set it offers no new word.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_acc)
            begin
            end
            else if (!hold_off && pending_reqs.size() > 0 && gap_left == 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {5'd0, pending_reqs[0]};
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left--;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        in_acc = s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_rsps.insert(expected_rsps.size(),
                                 allocate_step(req_t'(s_axis_tdata[18:0])));
            void'(pending_reqs.pop_front());
            sent++;
        end
    end

    // Receiver stall pattern, with a long hold when stall_long is set.
    int stall_cnt;
    always @(negedge clk)
    begin
        if (stall_long)
        begin
            stall_long = 1'b0;
            long_left = LONG_HOLD;
        end
        if (long_left > 0)
        begin
            m_axis_tready <= 1'b0;
            long_left--;
        end
        else if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt--;
        end
        else if ($urandom_range(0, 9) < 2)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt = $urandom_range(0, 8);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rsp_t a;
        rsp_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            a = rsp_t'(m_axis_tdata[29:0]);
            if (expected_rsps.size() == 0)
                report_mismatch("unexpected word", int'(m_axis_tdata), 0);
            else
            begin
                e = expected_rsps.pop_front();
                if (a.status !== e.status)
                    report_mismatch("status", a.status, e.status);
                if (a.block_number !== e.block_number)
                    report_mismatch("block_number", a.block_number, e.block_number);
                if (a.free_count !== e.free_count)
                    report_mismatch("free_count", a.free_count, e.free_count);
                if (a.file_blocks !== e.file_blocks)
                    report_mismatch("file_blocks", a.file_blocks, e.file_blocks);
                if (a.file_bytes !== e.file_bytes)
                    report_mismatch("file_bytes", a.file_bytes, e.file_bytes);
            end
            got++;
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_total(input logic [6:0] v);
        int t;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        t = (v == 0) ? 1 : (v > NBLK ? NBLK : int'(v));
        disk_refill(t);
    endtask

    // Random requests on random slots: creates, resizes, deletes and maps, with some oversized resizes.
    task automatic add_random(input int n);
        int s;
        for (int k = 0; k < n; k++)
        begin
            s = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0, 1:    queue_req(make_req(ACT_CREATE, s, $urandom, $urandom));
                2, 3, 4: queue_req(make_req(ACT_RESIZE, s,
                             ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                                         : $urandom_range(0, 256),
                             $urandom));
                5:       queue_req(make_req(ACT_DELETE, s, $urandom, $urandom));
                default: queue_req(make_req(ACT_MAP, s, $urandom,
                             $urandom_range(0, 15)));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        quiet = 0;
        sent = 0;
        got = 0;
        hold_off = 1'b0;
        stall_long = 1'b0;
        long_left = 0;
        in_acc = 1'b0;
        stall_cnt = 0;
        burst_left = 0;
        gap_left = 0;
        disk_refill(NBLK);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases.
        queue_req(make_req(ACT_MAP, 3, 0, 0));
        queue_req(make_req(ACT_RESIZE, 3, 16, 0));
        queue_req(make_req(ACT_DELETE, 3, 0, 0));
        queue_req(make_req(ACT_CREATE, 0, 0, 0));
        queue_req(make_req(ACT_CREATE, 0, 0, 0));
        queue_req(make_req(ACT_RESIZE, 0, 256, 0));
        queue_req(make_req(ACT_MAP, 0, 0, 15));
        queue_req(make_req(ACT_MAP, 0, 0, 0));
        queue_req(make_req(ACT_RESIZE, 0, 257, 0));
        queue_req(make_req(ACT_RESIZE, 0, 511, 0));
        queue_req(make_req(ACT_RESIZE, 0, 17, 0));
        queue_req(make_req(ACT_MAP, 0, 0, 2));
        queue_req(make_req(ACT_RESIZE, 0, 0, 0));
        queue_req(make_req(ACT_CREATE, 15, 0, 0));
        queue_req(make_req(ACT_RESIZE, 15, 255, 0));
        queue_req(make_req(ACT_DELETE, 15, 0, 0));
        queue_req(make_req(ACT_DELETE, 0, 0, 0));
        drain();

        // Tiny disk: full disk and no-space paths.
        write_total(7'd3);
        queue_req(make_req(ACT_CREATE, 1, 0, 0));
        queue_req(make_req(ACT_RESIZE, 1, 48, 0));
        queue_req(make_req(ACT_RESIZE, 1, 32, 0));
        queue_req(make_req(ACT_CREATE, 2, 0, 0));
        queue_req(make_req(ACT_CREATE, 4, 0, 0));
        queue_req(make_req(ACT_DELETE, 1, 0, 0));
        add_random(40);
        drain();

        write_total(7'd0);
        add_random(30);
        drain();

        write_total(7'd127);
        add_random(400);
        // Long receiver hold while the sender keeps offering.
        repeat (100) @(posedge clk);
        stall_long = 1'b1;
        drain();

        // Sender pauses until all results are back.
        write_total(7'd20);
        add_random(400);
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        while (expected_rsps.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
        hold_off = 1'b0;
        drain();

        write_total(7'd64);
        add_random(560);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/iba_pkg.sv
hw/rtl/indexed_block_allocator.sv
tb/tb_top.sv
